@@ hw/rtl/rdrs_pkg.sv @@
// shared types and constants for the rabin root-select decryptor
`timescale 1ns / 1ps

package rdrs_pkg;

    // modulus and operand width of the modular arithmetic
    localparam int MW = 32;
    // plaintext limit width
    localparam int LW = 16;

    // register reset values
    localparam int RST_P     = 331;
    localparam int RST_Q     = 311;
    localparam int RST_N     = 102941;
    localparam int RST_LIMIT = 128;

    // configuration register indexes
    localparam logic [1:0] CFG_PRIME_P = 2'd0;
    localparam logic [1:0] CFG_PRIME_Q = 2'd1;
    localparam logic [1:0] CFG_MOD_N   = 2'd2;
    localparam logic [1:0] CFG_LIMIT   = 2'd3;

    // datapath operations
    typedef enum logic [3:0] {
        OP_INIT,
        OP_BASE,
        OP_MUL,
        OP_SQR,
        OP_STORE,
        OP_EU_DIV,
        OP_RED_U,
        OP_RED_V,
        OP_UP,
        OP_VQ,
        OP_RP,
        OP_RQ,
        OP_COMB,
        OP_SEL,
        OP_ZERO,
        OP_EMIT
    } dp_op_t;

    // command from controller to datapath
    typedef struct packed {
        logic   go;
        dp_op_t op;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic done;
        logic exp_zero;
        logic exp_lsb;
        logic exp_one;
        logic pm_zero;
        logic eu_b_zero;
        logic n_zero;
        logic pw_q;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/rdrs_mulmod.sv @@
// serial modular multiplier: (a * b) mod m, with the quotient kept
`timescale 1ns / 1ps

module rdrs_mulmod
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [rdrs_pkg::MW-1:0] a,
    input  logic [rdrs_pkg::MW-1:0] b,
    input  logic [rdrs_pkg::MW-1:0] m,
    output logic                   done,
    output logic [rdrs_pkg::MW-1:0] rem,
    output logic [rdrs_pkg::MW-1:0] quo
);

    localparam int MW = rdrs_pkg::MW;
    localparam int PW = 2 * MW;
    localparam int SW = $clog2(PW + 1);

    logic          busy_reg;
    logic [SW-1:0] cnt_reg;
    logic          done_reg;
    logic [PW-1:0] prod_reg;
    logic [MW-1:0] rem_reg;
    logic [MW-1:0] quo_reg;
    logic [MW-1:0] m_reg;
    logic [MW:0]   trial;
    logic          fits;

    // one restoring step: bring in the next product bit
    always_comb
    begin
        trial = {rem_reg, prod_reg[PW-1]};
        fits  = (trial >= {1'b0, m_reg});
    end

    // step counter and completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SW'(PW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'(a) * PW'(b);
            m_reg    <= m;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= fits ? MW'(trial - {1'b0, m_reg}) : MW'(trial);
            quo_reg  <= {quo_reg[MW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

@@ hw/rtl/rdrs_datapath.sv @@
// datapath: exponentiation, euclid, crt combination and result register
`timescale 1ns / 1ps

module rdrs_datapath #(
    parameter int PRIME_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rdrs_pkg::cmd_t          cmd,
    output rdrs_pkg::sts_t          sts,
    input  logic [rdrs_pkg::MW-1:0] ciphertext,
    input  logic [PRIME_BITS-1:0]   prime_p,
    input  logic [PRIME_BITS-1:0]   prime_q,
    input  logic [rdrs_pkg::MW-1:0] modulus_n,
    input  logic [rdrs_pkg::LW-1:0] plaintext_limit,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [rdrs_pkg::MW-1:0] out_plaintext,
    output logic                    out_found
);

    localparam int MW = rdrs_pkg::MW;
    localparam int PB = PRIME_BITS;
    localparam int EW = PRIME_BITS;
    localparam int CW = PRIME_BITS + 2;

    rdrs_pkg::dp_op_t op_reg;
    logic             done_reg;
    logic             out_valid_reg;
    logic             pw_q_reg;

    logic [MW-1:0]        c_reg, acc_reg, base_reg, mp_reg, mq_reg;
    logic [EW-1:0]        exp_reg;
    logic [PB-1:0]        eu_a_reg, eu_b_reg;
    logic signed [CW-1:0] x_reg, y_reg, lx_reg, ly_reg;
    logic [MW-1:0]        ru_reg, rv_reg, up_reg, vq_reg, rp_reg, rq_reg, r_reg, s_reg;
    logic [MW-1:0]        res_plain_reg, out_plain_reg;
    logic                 res_found_reg, out_found_reg;

    logic          mm_start, mm_done, is_mm;
    logic [MW-1:0] mm_a, mm_b, mm_m, mm_rem, mm_quo;
    logic [MW-1:0] pm, lim_ext, red_val, store_val, nr, ns;
    logic [MW:0]   sum;
    logic [CW-1:0] lx_abs, ly_abs;
    logic          red_neg;
    logic signed [PB:0]   quo_s;
    logic [EW-1:0]        exp_p, exp_q;

    // working modulus of the exponentiation and small helpers
    always_comb
    begin
        pm      = pw_q_reg ? MW'(prime_q) : MW'(prime_p);
        lim_ext = MW'(plaintext_limit);
        exp_p   = EW'(({1'b0, prime_p} + 1'b1) >> 2);
        exp_q   = EW'(({1'b0, prime_q} + 1'b1) >> 2);
        lx_abs  = lx_reg[CW-1] ? CW'(-lx_reg) : CW'(lx_reg);
        ly_abs  = ly_reg[CW-1] ? CW'(-ly_reg) : CW'(ly_reg);
        quo_s   = $signed({1'b0, mm_quo[PB-1:0]});
        red_neg = (op_reg == rdrs_pkg::OP_RED_U) ? lx_reg[CW-1] : ly_reg[CW-1];
        red_val = (red_neg && (mm_rem != '0)) ? (modulus_n - mm_rem) : mm_rem;
        store_val = (pm == '0) ? '0 : acc_reg;
        sum     = {1'b0, rp_reg} + {1'b0, rq_reg};
        nr      = modulus_n - r_reg;
        ns      = modulus_n - s_reg;
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        is_mm = 1'b1;
        mm_a  = '0;
        mm_b  = MW'(1);
        mm_m  = modulus_n;
        case (cmd.op)
            rdrs_pkg::OP_BASE:
            begin
                mm_a = c_reg;
                mm_m = pm;
            end
            rdrs_pkg::OP_MUL:
            begin
                mm_a = acc_reg;
                mm_b = base_reg;
                mm_m = pm;
            end
            rdrs_pkg::OP_SQR:
            begin
                mm_a = base_reg;
                mm_b = base_reg;
                mm_m = pm;
            end
            rdrs_pkg::OP_EU_DIV:
            begin
                mm_a = MW'(eu_a_reg);
                mm_m = MW'(eu_b_reg);
            end
            rdrs_pkg::OP_RED_U: mm_a = MW'(lx_abs);
            rdrs_pkg::OP_RED_V: mm_a = MW'(ly_abs);
            rdrs_pkg::OP_UP:
            begin
                mm_a = ru_reg;
                mm_b = MW'(prime_p);
            end
            rdrs_pkg::OP_VQ:
            begin
                mm_a = rv_reg;
                mm_b = MW'(prime_q);
            end
            rdrs_pkg::OP_RP:
            begin
                mm_a = up_reg;
                mm_b = mq_reg;
            end
            rdrs_pkg::OP_RQ:
            begin
                mm_a = vq_reg;
                mm_b = mp_reg;
            end
            default: is_mm = 1'b0;
        endcase
        mm_start = cmd.go && is_mm;
    end

    rdrs_mulmod u_mulmod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (mm_m),
        .done  (mm_done),
        .rem   (mm_rem),
        .quo   (mm_quo)
    );

    // control registers: completion, pending op, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= rdrs_pkg::OP_INIT;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pw_q_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.go && !is_mm) || mm_done;
            if (cmd.go)
                op_reg <= cmd.op;
            if (cmd.go && (cmd.op == rdrs_pkg::OP_EMIT))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.go && (cmd.op == rdrs_pkg::OP_INIT))
                pw_q_reg <= 1'b0;
            else if (cmd.go && (cmd.op == rdrs_pkg::OP_STORE))
                pw_q_reg <= !pw_q_reg;
        end
    end

    // single-cycle operations
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            case (cmd.op)
                rdrs_pkg::OP_INIT:
                begin
                    c_reg    <= ciphertext;
                    exp_reg  <= exp_p;
                    acc_reg  <= MW'(1);
                    eu_a_reg <= prime_p;
                    eu_b_reg <= prime_q;
                    x_reg    <= '0;
                    y_reg    <= CW'(1);
                    lx_reg   <= CW'(1);
                    ly_reg   <= '0;
                end
                rdrs_pkg::OP_STORE:
                begin
                    if (!pw_q_reg)
                    begin
                        mp_reg  <= store_val;
                        exp_reg <= exp_q;
                        acc_reg <= MW'(1);
                    end
                    else
                    begin
                        mq_reg <= store_val;
                    end
                end
                rdrs_pkg::OP_COMB:
                begin
                    r_reg <= (sum >= {1'b0, modulus_n}) ? MW'(sum - {1'b0, modulus_n})
                                                        : MW'(sum);
                    s_reg <= (rp_reg >= rq_reg) ? (rp_reg - rq_reg)
                                                : (rp_reg + modulus_n - rq_reg);
                end
                rdrs_pkg::OP_SEL:
                begin
                    if (r_reg < lim_ext)
                    begin
                        res_plain_reg <= r_reg;
                        res_found_reg <= 1'b1;
                    end
                    else if (nr < lim_ext)
                    begin
                        res_plain_reg <= nr;
                        res_found_reg <= 1'b1;
                    end
                    else if (s_reg < lim_ext)
                    begin
                        res_plain_reg <= s_reg;
                        res_found_reg <= 1'b1;
                    end
                    else
                    begin
                        res_plain_reg <= ns;
                        res_found_reg <= 1'b0;
                    end
                end
                rdrs_pkg::OP_ZERO:
                begin
                    res_plain_reg <= '0;
                    res_found_reg <= 1'b0;
                end
                rdrs_pkg::OP_EMIT:
                begin
                    out_plain_reg <= res_plain_reg;
                    out_found_reg <= res_found_reg;
                end
                default:
                begin
                end
            endcase
        end
        // write back the multiplier result
        else if (mm_done)
        begin
            case (op_reg)
                rdrs_pkg::OP_BASE: base_reg <= mm_rem;
                rdrs_pkg::OP_MUL:  acc_reg  <= mm_rem;
                rdrs_pkg::OP_SQR:
                begin
                    base_reg <= mm_rem;
                    exp_reg  <= exp_reg >> 1;
                end
                rdrs_pkg::OP_EU_DIV:
                begin
                    eu_a_reg <= eu_b_reg;
                    eu_b_reg <= mm_rem[PB-1:0];
                    x_reg    <= lx_reg - CW'(quo_s * x_reg);
                    lx_reg   <= x_reg;
                    y_reg    <= ly_reg - CW'(quo_s * y_reg);
                    ly_reg   <= y_reg;
                end
                rdrs_pkg::OP_RED_U: ru_reg <= red_val;
                rdrs_pkg::OP_RED_V: rv_reg <= red_val;
                rdrs_pkg::OP_UP:    up_reg <= mm_rem;
                rdrs_pkg::OP_VQ:    vq_reg <= mm_rem;
                rdrs_pkg::OP_RP:    rp_reg <= mm_rem;
                rdrs_pkg::OP_RQ:    rq_reg <= mm_rem;
                default:
                begin
                end
            endcase
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.done      = done_reg;
        sts.exp_zero  = (exp_reg == '0);
        sts.exp_lsb   = exp_reg[0];
        sts.exp_one   = (exp_reg == EW'(1));
        sts.pm_zero   = (pm == '0);
        sts.eu_b_zero = (eu_b_reg == '0);
        sts.n_zero    = (modulus_n == '0);
        sts.pw_q      = pw_q_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign out_plaintext = out_plain_reg;
    assign out_found     = out_found_reg;

endmodule

@@ hw/rtl/rdrs_ctrl.sv @@
// controller: sequences the datapath operations for one ciphertext
`timescale 1ns / 1ps

module rdrs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rdrs_pkg::sts_t sts,
    output rdrs_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_POW_CHK,
        S_POW_BASE,
        S_POW_STEP,
        S_POW_MUL,
        S_POW_SQR,
        S_POW_STORE,
        S_EU_CHK,
        S_EU_DIV,
        S_RED_U,
        S_RED_V,
        S_UP,
        S_VQ,
        S_RP,
        S_RQ,
        S_COMB,
        S_SEL,
        S_ZERO,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   pend_reg;

    // command decode from the current state
    always_comb
    begin
        cmd.go = !pend_reg;
        cmd.op = rdrs_pkg::OP_INIT;
        case (state_reg)
            S_IDLE:      cmd.go = in_valid;
            S_INIT:      cmd.go = 1'b0;
            S_POW_BASE:  cmd.op = rdrs_pkg::OP_BASE;
            S_POW_MUL:   cmd.op = rdrs_pkg::OP_MUL;
            S_POW_SQR:   cmd.op = rdrs_pkg::OP_SQR;
            S_POW_STORE: cmd.op = rdrs_pkg::OP_STORE;
            S_EU_DIV:    cmd.op = rdrs_pkg::OP_EU_DIV;
            S_RED_U:     cmd.op = rdrs_pkg::OP_RED_U;
            S_RED_V:     cmd.op = rdrs_pkg::OP_RED_V;
            S_UP:        cmd.op = rdrs_pkg::OP_UP;
            S_VQ:        cmd.op = rdrs_pkg::OP_VQ;
            S_RP:        cmd.op = rdrs_pkg::OP_RP;
            S_RQ:        cmd.op = rdrs_pkg::OP_RQ;
            S_COMB:      cmd.op = rdrs_pkg::OP_COMB;
            S_SEL:       cmd.op = rdrs_pkg::OP_SEL;
            S_ZERO:      cmd.op = rdrs_pkg::OP_ZERO;
            S_EMIT:
            begin
                cmd.op = rdrs_pkg::OP_EMIT;
                cmd.go = !pend_reg && sts.out_free;
            end
            default:     cmd.go = 1'b0;
        endcase
        in_ready = (state_reg == S_IDLE);
    end

    // state and pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.go)
                pend_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    if (sts.done)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= sts.n_zero ? S_ZERO : S_POW_CHK;
                    end
                end
                // decision states take no datapath operation
                S_POW_CHK:
                    state_reg <= (sts.pm_zero || sts.exp_zero) ? S_POW_STORE : S_POW_BASE;
                S_POW_STEP:
                    state_reg <= sts.exp_lsb ? S_POW_MUL : S_POW_SQR;
                S_EU_CHK:
                    state_reg <= sts.eu_b_zero ? S_RED_U : S_EU_DIV;
                default:
                begin
                    if (sts.done)
                    begin
                        pend_reg <= 1'b0;
                        case (state_reg)
                            S_POW_BASE:  state_reg <= S_POW_STEP;
                            S_POW_MUL:   state_reg <= sts.exp_one ? S_POW_STORE : S_POW_SQR;
                            S_POW_SQR:   state_reg <= S_POW_STEP;
                            S_POW_STORE: state_reg <= sts.pw_q ? S_POW_CHK : S_EU_CHK;
                            S_EU_DIV:    state_reg <= S_EU_CHK;
                            S_RED_U:     state_reg <= S_RED_V;
                            S_RED_V:     state_reg <= S_UP;
                            S_UP:        state_reg <= S_VQ;
                            S_VQ:        state_reg <= S_RP;
                            S_RP:        state_reg <= S_RQ;
                            S_RQ:        state_reg <= S_COMB;
                            S_COMB:      state_reg <= S_SEL;
                            S_SEL:       state_reg <= S_EMIT;
                            S_ZERO:      state_reg <= S_EMIT;
                            default:     state_reg <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/rabin_decrypt_root_select_top.sv @@
// top level: rabin decryption with root selection
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata = ciphertext
//  m_*      out  m_tvalid/m_tready    m_tdata = plaintext, m_tuser = root_found
//  cfg_*    in   cfg_we               cfg_index, cfg_wdata
//
// one ciphertext at a time; every modular product goes through one serial
// multiplier of 64 restoring steps, and each product holds the controller until
// the multiplier is done. a modulus of zero skips all arithmetic and goes
// straight to a zero result. reset is asynchronous, active low, clears control
// state and loads the configuration registers with their reset values.
// a new beat is taken while the previous result waits in the output register.
`timescale 1ns / 1ps

module rabin_decrypt_root_select_top #(
    parameter int PRIME_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // [31:0] ciphertext
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // [31:0] plaintext
    output logic                    m_tuser,   // [0] root_found
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_wdata
);

    localparam int LW = rdrs_pkg::LW;

    logic [PRIME_BITS-1:0] prime_p_reg, prime_q_reg;
    logic [31:0]           modulus_n_reg;
    logic [LW-1:0]         limit_reg;
    rdrs_pkg::cmd_t        cmd;
    rdrs_pkg::sts_t        sts;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg   <= PRIME_BITS'(rdrs_pkg::RST_P);
            prime_q_reg   <= PRIME_BITS'(rdrs_pkg::RST_Q);
            modulus_n_reg <= 32'(rdrs_pkg::RST_N);
            limit_reg     <= LW'(rdrs_pkg::RST_LIMIT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdrs_pkg::CFG_PRIME_P: prime_p_reg   <= cfg_wdata[PRIME_BITS-1:0];
                rdrs_pkg::CFG_PRIME_Q: prime_q_reg   <= cfg_wdata[PRIME_BITS-1:0];
                rdrs_pkg::CFG_MOD_N:   modulus_n_reg <= cfg_wdata;
                rdrs_pkg::CFG_LIMIT:   limit_reg     <= cfg_wdata[LW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rdrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rdrs_datapath #(
        .PRIME_BITS (PRIME_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .ciphertext      (s_tdata),
        .prime_p         (prime_p_reg),
        .prime_q         (prime_q_reg),
        .modulus_n       (modulus_n_reg),
        .plaintext_limit (limit_reg),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_plaintext   (m_tdata),
        .out_found       (m_tuser)
    );

endmodule

@@ tb/testbench.sv @@
// self-checking bench for the rabin root-select decryptor
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [31:0] plaintext;
        logic        root_found;
    } root_t;

    // holds the register copy, predicts the chosen root and checks what comes out
    class root_book;
        logic [15:0] p_reg;
        logic [15:0] q_reg;
        logic [31:0] n_reg;
        logic [15:0] lim_reg;
        root_t       expected_roots[$];
        int          mismatches;
        int          decrypted;
        int          hits;

        function void reset_regs();
            p_reg   = 16'(rdrs_pkg::RST_P);
            q_reg   = 16'(rdrs_pkg::RST_Q);
            n_reg   = 32'(rdrs_pkg::RST_N);
            lim_reg = 16'(rdrs_pkg::RST_LIMIT);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                rdrs_pkg::CFG_PRIME_P: p_reg   = val[15:0];
                rdrs_pkg::CFG_PRIME_Q: q_reg   = val[15:0];
                rdrs_pkg::CFG_MOD_N:   n_reg   = val;
                rdrs_pkg::CFG_LIMIT:   lim_reg = val[15:0];
                default: ;
            endcase
        endfunction

        // square-and-multiply, modulus below 2^32
        function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex, logic [63:0] m);
            logic [63:0] acc;
            acc = 64'd1;
            if (m == 0)
                return 64'd0;
            base = base % m;
            while (ex > 0)
            begin
                if (ex[0])
                    acc = (acc * base) % m;
                base = (base * base) % m;
                ex = ex >> 1;
            end
            return acc;
        endfunction

        // signed value folded into [0, n)
        function logic [63:0] fold(longint v, logic [63:0] n);
            longint nn;
            longint r;
            nn = longint'(n);
            r  = v % nn;
            if (r < 0)
                r += nn;
            return r;
        endfunction

        function root_t select_root(logic [31:0] c);
            root_t       res;
            logic [63:0] n, p, q, lim, a, b, rem, mp, mq, up, vq, rp, rq, r, s;
            longint      x, y, lx, ly, quo, t;
            n   = 64'(n_reg);
            p   = 64'(p_reg);
            q   = 64'(q_reg);
            lim = 64'(lim_reg);
            if (n == 0)
            begin
                res.plaintext  = '0;
                res.root_found = 1'b0;
                return res;
            end
            mp = pow_mod(64'(c), (p + 1) / 4, p);
            mq = pow_mod(64'(c), (q + 1) / 4, q);
            // extended euclid, u stays with p and v with q
            a = p; b = q; x = 0; y = 1; lx = 1; ly = 0;
            while (b != 0)
            begin
                quo = longint'(a / b);
                rem = a % b;
                a = b;
                b = rem;
                t = x; x = lx - quo * x; lx = t;
                t = y; y = ly - quo * y; ly = t;
            end
            up = (fold(lx, n) * (p % n)) % n;
            vq = (fold(ly, n) * (q % n)) % n;
            rp = (up * (mq % n)) % n;
            rq = (vq * (mp % n)) % n;
            r  = (rp + rq) % n;
            s  = (rp + n - rq) % n;
            if (r < lim)
            begin
                res.plaintext = r[31:0]; res.root_found = 1'b1;
            end
            else if (n - r < lim)
            begin
                res.plaintext = 32'(n - r); res.root_found = 1'b1;
            end
            else if (s < lim)
            begin
                res.plaintext = s[31:0]; res.root_found = 1'b1;
            end
            else
            begin
                res.plaintext = 32'(n - s); res.root_found = 1'b0;
            end
            return res;
        endfunction

        function void note_ciphertext(logic [31:0] c);
            expected_roots.insert(expected_roots.size(), select_root(c));
        endfunction

        function void check_plaintext(logic [31:0] pt, logic found);
            root_t want;
            if (expected_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: plaintext %h found %b", pt, found);
                return;
            end
            want = expected_roots.pop_front();
            decrypted++;
            if (found)
                hits++;
            if (pt !== want.plaintext || found !== want.root_found)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%b, got %h/%b",
                             want.plaintext, want.root_found, pt, found);
            end
        endfunction

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    root_book    book;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_left;
    int          configs_used;

    // small primes that are 3 mod 4 keep each decryption short
    int          small_primes[13] = '{3, 7, 11, 19, 23, 31, 43, 47, 59, 67, 71, 79, 83};

    rabin_decrypt_root_select_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial clk = 0;
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // beat monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            book.note_ciphertext(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            book.check_plaintext(m_tdata, m_tuser);
    end

    // receiver: random stalls plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    initial
    begin
        #300_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        book.write_reg(idx, val);
    endtask

    task automatic set_regs(logic [15:0] p, logic [15:0] q, logic [31:0] n, logic [15:0] lim);
        write_reg(rdrs_pkg::CFG_PRIME_P, 32'(p));
        write_reg(rdrs_pkg::CFG_PRIME_Q, 32'(q));
        write_reg(rdrs_pkg::CFG_MOD_N, n);
        write_reg(rdrs_pkg::CFG_LIMIT, 32'(lim));
        configs_used++;
    endtask

    // one ciphertext beat, with a random idle gap in front
    task automatic send_cipher(logic [31:0] c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        else
            @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // mostly true squares of roots under the limit, some noise
    task automatic random_batch(int count);
        logic [63:0] m;
        logic [63:0] n;
        for (int i = 0; i < count; i++)
        begin
            n = 64'(book.n_reg);
            if (n != 0 && $urandom_range(99) < 70)
            begin
                m = (book.lim_reg != 0 && $urandom_range(3) != 0) ?
                    64'($urandom_range(book.lim_reg - 1)) : 64'($urandom);
                send_cipher(32'((m * m) % n));
            end
            else if (n != 0 && $urandom_range(1) == 0)
                send_cipher($urandom % book.n_reg);
            else
                send_cipher($urandom);
        end
    endtask

    task automatic random_regs();
        int          p, q;
        logic [31:0] n;
        logic [15:0] lim;
        p = small_primes[$urandom_range(12)];
        q = small_primes[$urandom_range(12)];
        while (q == p)
            q = small_primes[$urandom_range(12)];
        n = 32'(p * q);
        case ($urandom_range(9))
            0: n = $urandom;
            1: n = '0;
            default: ;
        endcase
        case ($urandom_range(5))
            0: lim = 16'($urandom);
            1: lim = '0;
            2: lim = 16'hFFFF;
            default: lim = 16'($urandom_range(1, 128));
        endcase
        set_regs(16'(p), 16'(q), n, lim);
    endtask

    initial
    begin
        book           = new();
        book.reset_regs();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        configs_used   = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = rdrs_pkg::CFG_PRIME_P;
        cfg_wdata      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset registers, field extremes, ciphertext above n
        send_cipher(32'd0);
        send_cipher(32'hFFFF_FFFF);
        send_cipher(32'd10000);
        send_cipher(32'd25);
        send_cipher(32'd200000);
        drain();
        // zero prime, exponent-zero primes, zero modulus
        set_regs(16'd0, 16'd7, 32'd77, 16'd40);
        send_cipher(32'd4);
        drain();
        set_regs(16'd2, 16'd1, 32'd2, 16'd2);
        send_cipher(32'd1);
        send_cipher(32'd3);
        drain();
        set_regs(16'd7, 16'd11, 32'd0, 16'd10);
        send_cipher(32'd5);
        send_cipher(32'hAAAA_5555);
        drain();
        // zero limit, largest limit, largest modulus, inconsistent registers
        set_regs(16'd7, 16'd11, 32'd77, 16'd0);
        send_cipher(32'd9);
        drain();
        set_regs(16'd7, 16'd11, 32'd77, 16'hFFFF);
        send_cipher(32'd9);
        drain();
        set_regs(16'd5, 16'd9, 32'hFFFF_FFFF, 16'd100);
        send_cipher(32'h1234_5678);
        send_cipher(32'hFFFF_FFFE);
        drain();
        set_regs(16'hFFFF, 16'd65519, 32'hFFEE_FFFF, 16'hFFFF);
        send_cipher(32'h5555_AAAA);
        send_cipher(32'd49);
        drain();

        // random: four idling phases of thirteen settings each
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int b = 0; b < 13; b++)
            begin
                if (ph == 2 && b == 0)
                    set_regs(16'd65519, 16'd65503, 32'hFFEF_0025, 16'hFFFF);
                else
                    random_regs();
                // long receiver hold-off while beats keep coming
                if (ph == 0 && b == 1)
                    hold_request = 4000;
                random_batch((ph == 2 && b == 0) ? 8 : 25);
                drain();
            end
        end

        repeat (200) @(posedge clk);
        $display("%0d ciphertexts decrypted under %0d register settings,",
                 book.decrypted, configs_used);
        $display("%0d with a qualifying root, %0d mismatches", book.hits, book.mismatches);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
